// File: rtl/core/cfbq_pkg.sv
`timescale 1ns / 1ps
// Package for the camera-facing beam quad core.
// Holds the register indexes, fixed field widths and arithmetic constants; no dependencies.

package cfbq_pkg;

  // Configuration port layout.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SHADE_LEVEL = 1'b1;

  localparam int unsigned HALF_WIDTH_W = 31;
  localparam int unsigned SHADE_W      = 32;

  localparam logic [HALF_WIDTH_W-1:0] HALF_WIDTH_RST = 31'd65536;
  localparam logic [SHADE_W-1:0]      SHADE_RST      = 32'd65536;

  // Shade level that stands for full brightness (1.0 in Q16.16).
  localparam logic [SHADE_W-1:0] SHADE_ONE = 32'd65536;

  // Output field widths.
  localparam int unsigned VTX_W        = 2;
  localparam int unsigned SHADE_BYTE_W = 8;

  localparam logic [VTX_W-1:0] VTX_FIRST = 2'd0;
  localparam logic [VTX_W-1:0] VTX_LAST  = 2'd3;

  // Vectors are scaled so every component magnitude stays below 2^FRAC_BITS.
  localparam int unsigned FRAC_BITS = 30;
  localparam int unsigned SHIFT_W   = 6;

  // Bit-serial unit depths: one root bit or one quotient bit per stage.
  localparam int unsigned SQRT_STEPS = 31;
  localparam int unsigned DIV_STEPS  = 31;

endpackage

// File: rtl/core/cfbq_beam_if.sv
`timescale 1ns / 1ps
// Input channel of the camera-facing beam quad core: one beam per item.
// Depends on nothing but its width parameter.

interface cfbq_beam_if #(
  parameter int unsigned COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] head_x;
  logic signed [COORD_WIDTH-1:0] head_y;
  logic signed [COORD_WIDTH-1:0] head_z;
  logic signed [COORD_WIDTH-1:0] tail_x;
  logic signed [COORD_WIDTH-1:0] tail_y;
  logic signed [COORD_WIDTH-1:0] tail_z;
  logic signed [COORD_WIDTH-1:0] cam_x;
  logic signed [COORD_WIDTH-1:0] cam_y;
  logic signed [COORD_WIDTH-1:0] cam_z;

  modport source (
    output valid, head_x, head_y, head_z, tail_x, tail_y, tail_z, cam_x, cam_y, cam_z,
    input  ready
  );

  modport sink (
    input  valid, head_x, head_y, head_z, tail_x, tail_y, tail_z, cam_x, cam_y, cam_z,
    output ready
  );
endinterface

// File: rtl/core/cfbq_vertex_if.sv
`timescale 1ns / 1ps
// Output channel of the camera-facing beam quad core: one quad vertex per item.
// Depends on cfbq_pkg for the fixed field widths.

interface cfbq_vertex_if #(
  parameter int unsigned COORD_WIDTH = 32
);
  logic                                   valid;
  logic                                   ready;
  logic signed [COORD_WIDTH-1:0]          vertex_x;
  logic signed [COORD_WIDTH-1:0]          vertex_y;
  logic signed [COORD_WIDTH-1:0]          vertex_z;
  logic [cfbq_pkg::VTX_W-1:0]             vertex_number;
  logic [cfbq_pkg::SHADE_BYTE_W-1:0]      shade_byte;
  logic                                   last_vertex;

  modport source (
    output valid, vertex_x, vertex_y, vertex_z, vertex_number, shade_byte, last_vertex,
    input  ready
  );

  modport sink (
    input  valid, vertex_x, vertex_y, vertex_z, vertex_number, shade_byte, last_vertex,
    output ready
  );
endinterface

// File: rtl/core/camera_facing_beam_quad_core.sv
`timescale 1ns / 1ps
// Camera-facing beam quad core: turns one beam into the four vertices of a billboard quad.
// Depends on cfbq_pkg, cfbq_beam_if and cfbq_vertex_if.
//
// Usage:
// Each item on beam_i carries a beam head, a beam tail and the camera position in signed
// Q16.16. For each beam the core sends four items on vertex_o, in the order head+L,
// tail+L, tail-L, head-L, where L is the unit normal of the plane through camera, head and
// tail, scaled by minus the half width. The fourth vertex has last_vertex set. Every vertex
// carries the grey level of the shade register.
// The configuration port writes half_width (index 0) and shade_level (index 1); write it
// only while no beam is in flight.
// The datapath is a 72-stage pipeline: differences, scaling, cross product, squares, a
// one-bit-per-stage square root of 31 stages and three one-bit-per-stage dividers of 31
// stages. The output port is the limit on throughput: it moves one vertex per cycle while
// the receiver is ready, and the pipeline holds until the quad ahead is fully taken; the
// next beam enters at the edge at which the last vertex of the quad ahead is taken.
// When the receiver stalls, the whole pipeline holds; nothing is lost or repeated.
// Reset clears all valid bits and loads the registers with a half width and shade of 1.0.

module camera_facing_beam_quad_core #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [cfbq_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [cfbq_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  cfbq_beam_if.sink                            beam_i,
  cfbq_vertex_if.source                        vertex_o
);

  localparam int unsigned CW  = COORD_WIDTH;
  // A difference of two coordinates needs one extra bit.
  localparam int unsigned MW  = CW + 1;
  localparam int unsigned FB  = cfbq_pkg::FRAC_BITS;
  localparam int unsigned SW  = cfbq_pkg::SHIFT_W;
  localparam int unsigned HW  = cfbq_pkg::HALF_WIDTH_W;
  localparam int unsigned NSQ = cfbq_pkg::SQRT_STEPS;
  localparam int unsigned NDV = cfbq_pkg::DIV_STEPS;
  // Scaled components, products and cross products.
  localparam int unsigned DW  = FB + 1;
  localparam int unsigned PW  = 2 * DW;
  localparam int unsigned CXW = PW + 1;
  localparam int unsigned CMW = PW;
  localparam int unsigned SQW = 2 * FB;
  localparam int unsigned N2W = SQW + 2;
  localparam int unsigned NUW = HW + FB;
  localparam int unsigned RTW = NSQ;
  localparam int unsigned RMW = RTW + 1;
  // Vertex sum width before saturation.
  localparam int unsigned LW  = HW + 1;
  localparam int unsigned EW  = ((CW > LW) ? CW : LW) + 2;

  // Stage numbering.
  localparam int unsigned ST_DIFF = 0;
  localparam int unsigned ST_MAG  = 1;
  localparam int unsigned ST_SHR  = 2;
  localparam int unsigned ST_PROD = 3;
  localparam int unsigned ST_CRS  = 4;
  localparam int unsigned ST_CMAG = 5;
  localparam int unsigned ST_CSHR = 6;
  localparam int unsigned ST_MUL  = 7;
  localparam int unsigned ST_N2   = 8;
  localparam int unsigned ST_SQ0  = 9;
  localparam int unsigned ST_DV0  = ST_SQ0 + NSQ;
  localparam int unsigned NPIPE   = ST_DV0 + NDV;
  localparam int unsigned CS_N    = NPIPE - ST_CMAG;

  // ---------------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------------
  logic [HW-1:0]                        half_width_q;
  logic [cfbq_pkg::SHADE_W-1:0]         shade_level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_width_q  <= cfbq_pkg::HALF_WIDTH_RST;
      shade_level_q <= cfbq_pkg::SHADE_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == cfbq_pkg::REG_HALF_WIDTH) begin
        half_width_q <= cfg_data_i[HW-1:0];
      end
      if (cfg_index_i == cfbq_pkg::REG_SHADE_LEVEL) begin
        shade_level_q <= cfg_data_i[cfbq_pkg::SHADE_W-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control. The whole pipeline advances together; it holds while the
  // quad register still has vertices that have not been taken.
  // ---------------------------------------------------------------------------
  logic               quad_valid_q;
  logic [cfbq_pkg::VTX_W-1:0] vcnt_q;
  logic               out_take;
  logic               adv;
  logic [NPIPE-1:0]   vld_q;

  assign out_take = vertex_o.valid && vertex_o.ready;
  assign adv      = !quad_valid_q || (out_take && (vcnt_q == cfbq_pkg::VTX_LAST));
  assign beam_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NPIPE-2:0], beam_i.valid};
    end
  end

  // Head and tail travel alongside the arithmetic to the vertex adders.
  logic signed [CW-1:0] head_q [NPIPE][3];
  logic signed [CW-1:0] tail_q [NPIPE][3];
  logic signed [CW-1:0] head_in [3];
  logic signed [CW-1:0] tail_in [3];
  logic signed [CW-1:0] cam_in  [3];

  assign head_in[0] = beam_i.head_x;
  assign head_in[1] = beam_i.head_y;
  assign head_in[2] = beam_i.head_z;
  assign tail_in[0] = beam_i.tail_x;
  assign tail_in[1] = beam_i.tail_y;
  assign tail_in[2] = beam_i.tail_z;
  assign cam_in[0]  = beam_i.cam_x;
  assign cam_in[1]  = beam_i.cam_y;
  assign cam_in[2]  = beam_i.cam_z;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      head_q[0] <= head_in;
      tail_q[0] <= tail_in;
      for (int s = 1; s < NPIPE; s++) begin
        head_q[s] <= head_q[s-1];
        tail_q[s] <= tail_q[s-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: differences a = cam - head (0..2) and b = tail - head (3..5).
  // ---------------------------------------------------------------------------
  logic signed [MW-1:0] diff_d [6];
  logic signed [MW-1:0] diff_q [6];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff_d[i]     = MW'(cam_in[i])  - MW'(head_in[i]);
      diff_d[3 + i] = MW'(tail_in[i]) - MW'(head_in[i]);
    end
  end

  // Stage 1: magnitudes, signs and the common shift that brings all six below 2^30.
  logic [MW-1:0] mag_d [6];
  logic [MW-1:0] mag_q [6];
  logic [5:0]    dsgn_q;
  logic [MW-1:0] mag_or;
  logic [SW-1:0] dshift_d;
  logic [SW-1:0] dshift_q;

  always_comb begin
    mag_or = '0;
    for (int i = 0; i < 6; i++) begin
      mag_d[i] = diff_q[i][MW-1] ? MW'(-diff_q[i]) : MW'(diff_q[i]);
      mag_or   = mag_or | mag_d[i];
    end
    dshift_d = '0;
    for (int b = FB; b < MW; b++) begin
      if (mag_or[b]) begin
        dshift_d = SW'(b - (FB - 1));
      end
    end
  end

  // Stage 2: scaled, signed components, truncated toward zero.
  logic [MW+FB-1:0]      dwide [6];
  logic signed [DW-1:0]  dsc_d [6];
  logic signed [DW-1:0]  dsc_q [6];

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      dwide[i] = {{FB{1'b0}}, mag_q[i]} >> dshift_q;
      dsc_d[i] = dsgn_q[i] ? -DW'(dwide[i][FB-1:0]) : DW'(dwide[i][FB-1:0]);
    end
  end

  // Stage 3: the six partial products of the cross product.
  logic signed [PW-1:0] prod_d [6];
  logic signed [PW-1:0] prod_q [6];

  always_comb begin
    prod_d[0] = dsc_q[1] * dsc_q[5];
    prod_d[1] = dsc_q[2] * dsc_q[4];
    prod_d[2] = dsc_q[2] * dsc_q[3];
    prod_d[3] = dsc_q[0] * dsc_q[5];
    prod_d[4] = dsc_q[0] * dsc_q[4];
    prod_d[5] = dsc_q[1] * dsc_q[3];
  end

  // Stage 4: cross product components.
  logic signed [CXW-1:0] crs_d [3];
  logic signed [CXW-1:0] crs_q [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      crs_d[j] = CXW'(prod_q[2*j]) - CXW'(prod_q[2*j + 1]);
    end
  end

  // Stage 5: cross product magnitudes and the shift that brings them below 2^30.
  logic [CMW-1:0] cmag_d [3];
  logic [CMW-1:0] cmag_q [3];
  logic [CMW-1:0] cmag_or;
  logic [SW-1:0]  cshift_d;
  logic [SW-1:0]  cshift_q;
  logic [2:0]     csgn_q [CS_N];

  always_comb begin
    cmag_or = '0;
    for (int j = 0; j < 3; j++) begin
      cmag_d[j] = crs_q[j][CXW-1] ? CMW'(-crs_q[j]) : CMW'(crs_q[j]);
      cmag_or   = cmag_or | cmag_d[j];
    end
    cshift_d = '0;
    for (int b = FB; b < CMW; b++) begin
      if (cmag_or[b]) begin
        cshift_d = SW'(b - (FB - 1));
      end
    end
  end

  // Stage 6: scaled cross product magnitudes.
  logic [CMW-1:0] cwide [3];
  logic [FB-1:0]  csc_d [3];
  logic [FB-1:0]  csc_q [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      cwide[j] = cmag_q[j] >> cshift_q;
      csc_d[j] = cwide[j][FB-1:0];
    end
  end

  // Stage 7: squares for the norm and half_width * |c| for the divide.
  logic [SQW-1:0] sq_d  [3];
  logic [SQW-1:0] sq_q  [3];
  logic [NUW-1:0] num_d [3];
  logic [NUW-1:0] num7_q [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sq_d[j]  = csc_q[j] * csc_q[j];
      num_d[j] = half_width_q * csc_q[j];
    end
  end

  // Stage 8: squared norm.
  logic [N2W-1:0] n2_d;
  logic [N2W-1:0] n2_q;
  logic [NUW-1:0] num8_q [3];

  assign n2_d = N2W'(sq_q[0]) + N2W'(sq_q[1]) + N2W'(sq_q[2]);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      diff_q   <= diff_d;
      mag_q    <= mag_d;
      for (int i = 0; i < 6; i++) begin
        dsgn_q[i] <= diff_q[i][MW-1];
      end
      dshift_q <= dshift_d;
      dsc_q    <= dsc_d;
      prod_q   <= prod_d;
      crs_q    <= crs_d;
      cmag_q   <= cmag_d;
      cshift_q <= cshift_d;
      for (int j = 0; j < 3; j++) begin
        csgn_q[0][j] <= crs_q[j][CXW-1];
      end
      for (int s = 1; s < CS_N; s++) begin
        csgn_q[s] <= csgn_q[s-1];
      end
      csc_q    <= csc_d;
      sq_q     <= sq_d;
      num7_q   <= num_d;
      n2_q     <= n2_d;
      num8_q   <= num7_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Square root: one root bit per stage, restoring method.
  // ---------------------------------------------------------------------------
  logic [RMW-1:0] sq_rem_q  [NSQ];
  logic [RTW-1:0] sq_root_q [NSQ];
  logic [N2W-1:0] sq_x_q    [NSQ];
  logic [NUW-1:0] sq_num_q  [NSQ][3];

  for (genvar g = 0; g < NSQ; g++) begin : g_sqrt
    logic [RMW-1:0]   rem_in;
    logic [RTW-1:0]   root_in;
    logic [N2W-1:0]   x_in;
    logic [NUW-1:0]   num_in [3];
    logic [RMW+1:0]   remx;
    logic [RMW+1:0]   trial;
    logic [RMW-1:0]   rem_d;
    logic [RTW-1:0]   root_d;

    if (g == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = n2_q;
      assign num_in  = num8_q;
    end else begin : g_next
      assign rem_in  = sq_rem_q[g-1];
      assign root_in = sq_root_q[g-1];
      assign x_in    = sq_x_q[g-1];
      assign num_in  = sq_num_q[g-1];
    end

    always_comb begin
      remx  = {rem_in, x_in[2*(NSQ-1-g) +: 2]};
      trial = {1'b0, root_in, 2'b01};
      if (remx >= trial) begin
        rem_d  = RMW'(remx - trial);
        root_d = {root_in[RTW-2:0], 1'b1};
      end else begin
        rem_d  = RMW'(remx);
        root_d = {root_in[RTW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_rem_q[g]  <= rem_d;
        sq_root_q[g] <= root_d;
        sq_x_q[g]    <= x_in;
        sq_num_q[g]  <= num_in;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Three dividers, one quotient bit per stage. The quotient never exceeds
  // half_width, so the first partial remainder is the numerator's upper bits.
  // ---------------------------------------------------------------------------
  logic [RTW-1:0] dv_norm_q [NDV];
  logic [RTW-1:0] dv_rem_q  [NDV][3];
  logic [HW-1:0]  dv_quo_q  [NDV][3];
  logic [NDV-1:0] dv_low_q  [NDV][3];

  for (genvar g = 0; g < NDV; g++) begin : g_div
    logic [RTW-1:0] norm_in;
    logic [RTW-1:0] rem_in  [3];
    logic [HW-1:0]  quo_in  [3];
    logic [NDV-1:0] low_in  [3];
    logic [RTW:0]   part    [3];
    logic [RTW-1:0] rem_d   [3];
    logic [HW-1:0]  quo_d   [3];

    if (g == 0) begin : g_first
      assign norm_in = sq_root_q[NSQ-1];
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign rem_in[l] = RTW'(sq_num_q[NSQ-1][l][NUW-1:NDV]);
        assign quo_in[l] = '0;
        assign low_in[l] = sq_num_q[NSQ-1][l][NDV-1:0];
      end
    end else begin : g_next
      assign norm_in = dv_norm_q[g-1];
      assign rem_in  = dv_rem_q[g-1];
      assign quo_in  = dv_quo_q[g-1];
      assign low_in  = dv_low_q[g-1];
    end

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        part[l] = {rem_in[l], low_in[l][NDV-1-g]};
        if (part[l] >= {1'b0, norm_in}) begin
          rem_d[l] = RTW'(part[l] - {1'b0, norm_in});
          quo_d[l] = {quo_in[l][HW-2:0], 1'b1};
        end else begin
          rem_d[l] = RTW'(part[l]);
          quo_d[l] = {quo_in[l][HW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_norm_q[g] <= norm_in;
        dv_rem_q[g]  <= rem_d;
        dv_quo_q[g]  <= quo_d;
        dv_low_q[g]  <= low_in;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Quad register: lateral offset, the four vertices, saturation.
  // A zero norm means a degenerate beam and gives a zero offset.
  // ---------------------------------------------------------------------------
  logic signed [LW-1:0]  lat [3];
  logic signed [EW-1:0]  vsum [4][3];
  logic signed [CW-1:0]  quad_d [4][3];
  logic signed [CW-1:0]  quad_q [4][3];
  logic                  norm_zero;

  assign norm_zero = (dv_norm_q[NDV-1] == '0);

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (norm_zero) begin
        lat[j] = '0;
      end else if (csgn_q[CS_N-1][j]) begin
        lat[j] = LW'(dv_quo_q[NDV-1][j]);
      end else begin
        lat[j] = -LW'(dv_quo_q[NDV-1][j]);
      end
      vsum[0][j] = EW'(head_q[NPIPE-1][j]) + EW'(lat[j]);
      vsum[1][j] = EW'(tail_q[NPIPE-1][j]) + EW'(lat[j]);
      vsum[2][j] = EW'(tail_q[NPIPE-1][j]) - EW'(lat[j]);
      vsum[3][j] = EW'(head_q[NPIPE-1][j]) - EW'(lat[j]);
    end
    for (int v = 0; v < 4; v++) begin
      for (int j = 0; j < 3; j++) begin
        if ((&vsum[v][j][EW-1:CW-1]) || !(|vsum[v][j][EW-1:CW-1])) begin
          quad_d[v][j] = vsum[v][j][CW-1:0];
        end else if (vsum[v][j][EW-1]) begin
          quad_d[v][j] = {1'b1, {(CW-1){1'b0}}};
        end else begin
          quad_d[v][j] = {1'b0, {(CW-1){1'b1}}};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      quad_q <= quad_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quad_valid_q <= 1'b0;
      vcnt_q       <= cfbq_pkg::VTX_FIRST;
    end else begin
      if (adv) begin
        quad_valid_q <= vld_q[NPIPE-1];
      end
      if (out_take) begin
        vcnt_q <= vcnt_q + 1'b1;
      end
    end
  end

  // Grey level: clamp the shade to 0..1.0, then floor(s * 255 / 65536).
  logic [cfbq_pkg::SHADE_W-1:0] shade_clamp;
  logic [cfbq_pkg::SHADE_W-1:0] shade_scaled;

  always_comb begin
    if (shade_level_q[cfbq_pkg::SHADE_W-1]) begin
      shade_clamp = '0;
    end else if (shade_level_q > cfbq_pkg::SHADE_ONE) begin
      shade_clamp = cfbq_pkg::SHADE_ONE;
    end else begin
      shade_clamp = shade_level_q;
    end
    shade_scaled = (shade_clamp << 8) - shade_clamp;
  end

  assign vertex_o.valid         = quad_valid_q;
  assign vertex_o.vertex_x      = quad_q[vcnt_q][0];
  assign vertex_o.vertex_y      = quad_q[vcnt_q][1];
  assign vertex_o.vertex_z      = quad_q[vcnt_q][2];
  assign vertex_o.vertex_number = vcnt_q;
  assign vertex_o.shade_byte    = shade_scaled[16 +: cfbq_pkg::SHADE_BYTE_W];
  assign vertex_o.last_vertex   = (vcnt_q == cfbq_pkg::VTX_LAST);

endmodule

// File: rtl/core/cfbq_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the camera-facing beam quad core, and the bind that attaches it.
// Depends on cfbq_pkg and camera_facing_beam_quad_core.

module cfbq_checker #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              valid_i,
  input logic                              ready_i,
  input logic signed [COORD_WIDTH-1:0]     vertex_x_i,
  input logic [cfbq_pkg::VTX_W-1:0]        vertex_number_i,
  input logic                              last_vertex_i
);

  // The last flag marks exactly the fourth vertex.
  a_last_matches_number: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> (last_vertex_i == (vertex_number_i == cfbq_pkg::VTX_LAST)))
    else $error("last_vertex does not match vertex_number");

  // Within a quad the vertices follow one another without a gap.
  a_vertex_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && ready_i && !last_vertex_i) |=>
      (valid_i && (vertex_number_i == $past(vertex_number_i) + 2'd1)))
    else $error("quad vertex missing or out of order");

  // A new quad always starts at its first vertex.
  a_quad_starts_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && ready_i && last_vertex_i) |=>
      (!valid_i || (vertex_number_i == cfbq_pkg::VTX_FIRST)))
    else $error("quad does not start at its first vertex");

  // A stalled vertex stays on the port unchanged.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && !ready_i) |=>
      (valid_i && $stable(vertex_x_i) && $stable(vertex_number_i)))
    else $error("stalled vertex changed");

endmodule

bind camera_facing_beam_quad_core cfbq_checker #(
  .COORD_WIDTH(COORD_WIDTH)
) u_cfbq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .valid_i         (vertex_o.valid),
  .ready_i         (vertex_o.ready),
  .vertex_x_i      (vertex_o.vertex_x),
  .vertex_number_i (vertex_o.vertex_number),
  .last_vertex_i   (vertex_o.last_vertex)
);

// File: dv/cfbq_quad_checker.sv
`timescale 1ns / 1ps
// Checker for the camera-facing beam quad core: predicts the four vertices of every beam.
// Depends on cfbq_pkg, cfbq_beam_if and cfbq_vertex_if.

module cfbq_quad_checker #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cfbq_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [cfbq_pkg::CFG_DATA_W-1:0] cfg_data_i,
  cfbq_beam_if                            beam,
  cfbq_vertex_if                          vertex,
  output int                              fail_count_o,
  output int                              pending_o
);
  import cfbq_pkg::*;

  typedef struct {
    logic signed [COORD_WIDTH-1:0] x, y, z;
    logic [VTX_W-1:0]              number;
    logic [SHADE_BYTE_W-1:0]       shade;
    logic                          last;
  } vertex_t;

  vertex_t quad_q[$];
  logic [HALF_WIDTH_W-1:0] half_width_r;
  logic signed [SHADE_W-1:0] shade_level_r;
  int fails;
  int pend;

  assign fail_count_o = fails;
  assign pending_o    = pend;

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint shrink_by(longint v, int s);
    longint q;
    q = longint'(magnitude(v) >> s);
    return v < 0 ? -q : q;
  endfunction

  // Smallest shift that brings every magnitude below 2^FRAC_BITS.
  function automatic int fit_shift(longint v[], int n);
    longint unsigned m;
    int s;
    m = 0;
    s = 0;
    for (int i = 0; i < n; i++) if (magnitude(v[i]) > m) m = magnitude(v[i]);
    while ((m >> s) >= (64'd1 << FRAC_BITS)) s++;
    return s;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [COORD_WIDTH-1:0] clip_coord(longint p);
    longint hi, lo;
    hi = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
    lo = -hi - 1;
    if (p > hi) p = hi;
    if (p < lo) p = lo;
    return p[COORD_WIDTH-1:0];
  endfunction

  task automatic predict_quad(longint head[3], longint tail[3], longint cam[3]);
    longint d[], c[], lat[3], s, base, p;
    longint unsigned n2, n, q;
    int k;
    vertex_t vt;
    d = new[6];
    c = new[3];
    for (int i = 0; i < 3; i++) begin
      d[i]     = cam[i] - head[i];
      d[3 + i] = tail[i] - head[i];
    end
    k = fit_shift(d, 6);
    for (int i = 0; i < 6; i++) d[i] = shrink_by(d[i], k);
    c[0] = d[1] * d[5] - d[2] * d[4];
    c[1] = d[2] * d[3] - d[0] * d[5];
    c[2] = d[0] * d[4] - d[1] * d[3];
    k = fit_shift(c, 3);
    for (int i = 0; i < 3; i++) c[i] = shrink_by(c[i], k);
    n2 = 0;
    for (int i = 0; i < 3; i++) n2 += magnitude(c[i]) * magnitude(c[i]);
    n = root_floor(n2);
    for (int i = 0; i < 3; i++) begin
      if (n == 0) begin
        lat[i] = 0;
      end else begin
        q = (longint'(half_width_r) * magnitude(c[i])) / n;
        lat[i] = c[i] < 0 ? longint'(q) : -longint'(q);
      end
    end
    s = shade_level_r;
    if (s < 0) s = 0;
    if (s > longint'(SHADE_ONE)) s = SHADE_ONE;
    for (int v = 0; v < 4; v++) begin
      longint pt[3];
      for (int i = 0; i < 3; i++) begin
        base  = (v == 0 || v == 3) ? head[i] : tail[i];
        pt[i] = (v < 2) ? base + lat[i] : base - lat[i];
      end
      vt.x      = clip_coord(pt[0]);
      vt.y      = clip_coord(pt[1]);
      vt.z      = clip_coord(pt[2]);
      vt.number = v[VTX_W-1:0];
      vt.shade  = 8'((s * 255) >>> 16);
      vt.last   = (vt.number == VTX_LAST);
      quad_q.push_back(vt);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_width_r  <= HALF_WIDTH_RST;
      shade_level_r <= SHADE_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_HALF_WIDTH) half_width_r <= cfg_data_i[HALF_WIDTH_W-1:0];
      else if (cfg_index_i == REG_SHADE_LEVEL) shade_level_r <= cfg_data_i;
    end
  end

  initial begin
    fails = 0;
    pend  = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && beam.valid && beam.ready) begin
      longint h[3], t[3], cm[3];
      h  = '{beam.head_x, beam.head_y, beam.head_z};
      t  = '{beam.tail_x, beam.tail_y, beam.tail_z};
      cm = '{beam.cam_x, beam.cam_y, beam.cam_z};
      predict_quad(h, t, cm);
    end
    if (rst_ni && vertex.valid && vertex.ready) begin
      vertex_t ex;
      if (quad_q.size() == 0) begin
        $error("vertex item with no beam pending");
        fails++;
      end else begin
        ex = quad_q.pop_front();
        if (vertex.vertex_x !== ex.x) begin
          $error("vertex_x exp %0d act %0d", ex.x, vertex.vertex_x); fails++;
        end
        if (vertex.vertex_y !== ex.y) begin
          $error("vertex_y exp %0d act %0d", ex.y, vertex.vertex_y); fails++;
        end
        if (vertex.vertex_z !== ex.z) begin
          $error("vertex_z exp %0d act %0d", ex.z, vertex.vertex_z); fails++;
        end
        if (vertex.vertex_number !== ex.number) begin
          $error("vertex_number exp %0d act %0d", ex.number, vertex.vertex_number); fails++;
        end
        if (vertex.shade_byte !== ex.shade) begin
          $error("shade_byte exp %0d act %0d", ex.shade, vertex.shade_byte); fails++;
        end
        if (vertex.last_vertex !== ex.last) begin
          $error("last_vertex exp %0d act %0d", ex.last, vertex.last_vertex); fails++;
        end
      end
    end
    pend = quad_q.size();
  end
endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// Top of the camera-facing beam quad testbench: clock, reset, beam stimulus and verdict.
// Depends on cfbq_pkg, both channel interfaces, the core and cfbq_quad_checker.

module tb;
  import cfbq_pkg::*;

  localparam int unsigned CW = 32;
  // Cycles without any accepted item before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  int fail_count, pending;
  bit no_idle;

  cfbq_beam_if   #(.COORD_WIDTH(CW)) beam_ch ();
  cfbq_vertex_if #(.COORD_WIDTH(CW)) vertex_ch ();

  camera_facing_beam_quad_core #(.COORD_WIDTH(CW)) u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i), .beam_i(beam_ch), .vertex_o(vertex_ch)
  );

  cfbq_quad_checker #(.COORD_WIDTH(CW)) u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i), .beam(beam_ch), .vertex(vertex_ch),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Every input starts at a known value; reset is asserted once, at the start of the run.
  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    beam_ch.valid = 1'b0;
    {beam_ch.head_x, beam_ch.head_y, beam_ch.head_z} = '0;
    {beam_ch.tail_x, beam_ch.tail_y, beam_ch.tail_z} = '0;
    {beam_ch.cam_x, beam_ch.cam_y, beam_ch.cam_z}    = '0;
    vertex_ch.ready = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Receiver: a random hold-off before each vertex, no hold-off while no_idle is set, and
  // once a long stall so the pipeline fills and pushes back on beams.
  initial begin
    int gap, taken;
    gap = 0;
    taken = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (vertex_ch.valid && vertex_ch.ready) begin
        taken++;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (taken == 600) gap = 400;
      end
      if (gap > 0) begin
        vertex_ch.ready <= 1'b0;
        gap--;
      end else begin
        vertex_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: any accepted item on either channel restarts the count.
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((beam_ch.valid && beam_ch.ready) || (vertex_ch.valid && vertex_ch.ready)) idle = 0;
      else idle++;
      if (idle >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Called at a clock edge; returns at the edge where the beam is accepted.
  task automatic send_beam(logic [CW-1:0] h[3], logic [CW-1:0] t[3], logic [CW-1:0] c[3]);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      beam_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    beam_ch.head_x <= h[0]; beam_ch.head_y <= h[1]; beam_ch.head_z <= h[2];
    beam_ch.tail_x <= t[0]; beam_ch.tail_y <= t[1]; beam_ch.tail_z <= t[2];
    beam_ch.cam_x  <= c[0]; beam_ch.cam_y  <= c[1]; beam_ch.cam_z  <= c[2];
    beam_ch.valid  <= 1'b1;
    do @(posedge clk_i); while (!beam_ch.ready);
  endtask

  // Registers change only with nothing in flight: every vertex has arrived and the
  // pipeline has had time to drain. The first edge lets the checker count the last beam.
  task automatic write_regs(logic [CFG_DATA_W-1:0] hw, logic [CFG_DATA_W-1:0] sh);
    beam_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_index_i <= REG_HALF_WIDTH; cfg_data_i <= hw;
    @(posedge clk_i);
    cfg_index_i <= REG_SHADE_LEVEL; cfg_data_i <= sh;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [CW-1:0] rand_coord(int kind);
    case (kind)
      0: return CW'($signed($urandom_range(0, 2000000)) - 1000000);
      1: return $urandom();
      default: return ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff - $urandom_range(0, 255)
                                                  : 32'h8000_0000 + $urandom_range(0, 255);
    endcase
  endfunction

  // One random beam: half moderate scenes, the rest full-range beams, degenerate beams (tail on
  // the head, camera on the beam line) and beams near the edges of the range that saturate.
  task automatic send_random_beam();
    logic [CW-1:0] h[3], t[3], c[3];
    int kind, mult;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) begin
      h[i] = rand_coord(kind < 5 ? 0 : (kind < 8 ? 1 : 2));
      t[i] = rand_coord(kind < 5 ? 0 : (kind < 8 ? 1 : 2));
      c[i] = rand_coord(kind < 5 ? 0 : 1);
    end
    if (kind == 5) begin
      t = h;
    end else if (kind == 6) begin
      mult = $urandom_range(0, 6) - 3;
      for (int i = 0; i < 3; i++) begin
        t[i] = h[i] + CW'($signed($urandom_range(0, 20000)) - 10000);
        c[i] = h[i] + (t[i] - h[i]) * mult;
      end
    end
    send_beam(h, t, c);
  endtask

  initial begin
    logic [CW-1:0] mx, mn, z;
    logic [CFG_DATA_W-1:0] hw_set[6], sh_set[6];
    mx = 32'h7fff_ffff;
    mn = 32'h8000_0000;
    z  = '0;
    // Register settings per phase, extremes included.
    hw_set = '{32'd65536, 32'd0, 32'h7fff_ffff, 32'd1, $urandom() >> 1, 32'd32768};
    sh_set = '{32'd65536, 32'h8000_0000, 32'h7fff_ffff, 32'd0, $urandom(), 32'd40000};
    no_idle = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);

    // Directed beams at the reset settings.
    send_beam('{mx, mx, mx}, '{mx, mx, mx}, '{mx, mx, mx});
    send_beam('{mn, mn, mn}, '{mn, mn, mn}, '{mn, mn, mn});
    send_beam('{mn, mn, mn}, '{mx, mx, mx}, '{mx, mn, mx});
    send_beam('{mx, mn, mx}, '{mn, mx, mn}, '{mn, mn, mx});
    send_beam('{z, z, z}, '{32'h10000, z, z}, '{z, 32'h10000, z});
    send_beam('{z, z, z}, '{z, z, z}, '{32'h30000, 32'h1000, z});
    send_beam('{z, z, z}, '{32'h20000, 32'h20000, z}, '{32'h40000, 32'h40000, z});
    send_beam('{32'h50000, 1, 2}, '{32'h90000, 3, 4}, '{32'h50000, 1, 2});
    send_beam('{mx, z, z}, '{mx, 32'h10000, z}, '{mx, z, 32'h10000});
    send_beam('{mn, z, z}, '{mn, 32'h10000, z}, '{mn, z, 32'hffff_0000});
    send_beam('{32'hffff_ffff, 1, z}, '{1, 32'hffff_ffff, z}, '{z, z, 1});

    for (int ph = 0; ph < 6; ph++) begin
      write_regs(hw_set[ph], sh_set[ph]);
      for (int n = 0; n < 80; n++) begin
        // A stretch with no idling at the start of some phases.
        no_idle = (ph % 2 == 1) && (n < 25);
        send_random_beam();
      end
    end
    no_idle = 1'b0;
    beam_ch.valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// File: sim.f
rtl/core/cfbq_pkg.sv
rtl/core/cfbq_beam_if.sv
rtl/core/cfbq_vertex_if.sv
rtl/core/camera_facing_beam_quad_core.sv
rtl/core/cfbq_checker.sv
dv/cfbq_quad_checker.sv
dv/tb.sv
